@@ rtl/wpdc_pkg.sv @@
// Shared types, constants and fixed-point helpers for the waypoint drive controller.
`default_nettype none
package wpdc_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int CORDIC_STEPS_MAX = 32;

	localparam logic signed [20:0] PI_Q      = 21'sd205887;
	localparam logic signed [21:0] TWO_PI_Q  = 22'sd411775;
	localparam logic signed [17:0] LIN_MAX   = 18'sd45875;
	localparam logic [32:0]        KINV_Q20  = 33'd636751;
	localparam logic [65:0]        PROD_LIM  = 66'h7FFF_FFFF_FFFF;

	localparam logic [2:0] REG_GPA = 3'd0;
	localparam logic [2:0] REG_GIA = 3'd1;
	localparam logic [2:0] REG_GDA = 3'd2;
	localparam logic [2:0] REG_GPL = 3'd3;
	localparam logic [2:0] REG_GIL = 3'd4;
	localparam logic [2:0] REG_GDL = 3'd5;
	localparam logic [2:0] REG_TP  = 3'd6;
	localparam logic [2:0] REG_TR  = 3'd7;

	typedef logic signed [47:0] q48_t;

	function automatic logic signed [20:0] atan_q(input logic [4:0] i);
		logic signed [20:0] r;
		unique case (i)
			5'd0:  r = 21'sd51472;
			5'd1:  r = 21'sd30386;
			5'd2:  r = 21'sd16055;
			5'd3:  r = 21'sd8150;
			5'd4:  r = 21'sd4091;
			5'd5:  r = 21'sd2047;
			5'd6:  r = 21'sd1024;
			5'd7:  r = 21'sd512;
			5'd8:  r = 21'sd256;
			5'd9:  r = 21'sd128;
			5'd10: r = 21'sd64;
			5'd11: r = 21'sd32;
			5'd12: r = 21'sd16;
			5'd13: r = 21'sd8;
			5'd14: r = 21'sd4;
			5'd15: r = 21'sd2;
			5'd16: r = 21'sd1;
			default: r = 21'sd0;
		endcase
		return r;
	endfunction

	// truncate toward zero, saturate to +-(2^47 - 1)
	function automatic q48_t mulq_fix(input logic [81:0] p, input logic neg);
		logic [65:0] r;
		logic [47:0] m;
		r = p[81:16];
		m = (r > PROD_LIM) ? PROD_LIM[47:0] : r[47:0];
		return neg ? -$signed(m) : $signed(m);
	endfunction

	function automatic q48_t sat48(input logic signed [48:0] v);
		q48_t r;
		if (v > 49'sh0_7FFF_FFFF_FFFF) begin
			r = 48'sh7FFF_FFFF_FFFF;
		end else if (v < -49'sh0_8000_0000_0000) begin
			r = 48'sh8000_0000_0000;
		end else begin
			r = v[47:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ rtl/wpdc_mul.sv @@
// Sequential magnitude multiplier, 33 x 49 bits, one 16-bit digit per cycle.
`default_nettype none
module wpdc_mul (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [32:0] a,
	input  wire logic signed [49:0] b,
	output logic                    done,
	output logic                    neg,
	output logic [81:0]             prod
);
	logic [32:0] ua_q;
	logic [63:0] ub_q;
	logic [81:0] acc_q;
	logic [1:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic        neg_q;
	logic [32:0] amag;
	logic [49:0] bneg;
	logic [48:0] bmag;
	logic [48:0] part;

	assign amag = a[32] ? 33'(-a) : 33'(a);
	assign bneg = 50'(-b);
	assign bmag = b[49] ? bneg[48:0] : b[48:0];
	assign part = ua_q * ub_q[63:48];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ua_q  <= amag;
			ub_q  <= {15'd0, bmag};
			acc_q <= '0;
			neg_q <= a[32] ^ b[49];
		end else if (busy_q) begin
			acc_q <= {acc_q[65:0], 16'd0} + 82'(part);
			ub_q  <= {ub_q[47:0], 16'd0};
		end
	end

	assign done = done_q;
	assign neg  = neg_q;
	assign prod = acc_q;
endmodule
`default_nettype wire

@@ rtl/wpdc_cordic.sv @@
// Iterative CORDIC vectoring unit: magnitude and angle of a position difference.
`default_nettype none
module wpdc_cordic #(
	parameter int STEPS = wpdc_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [32:0] ex,
	input  wire logic signed [32:0] ey,
	output logic                    done,
	output logic [43:0]             mag,
	output logic signed [20:0]      ang
);
	localparam int NSTEP = (STEPS > wpdc_pkg::CORDIC_STEPS_MAX) ?
		wpdc_pkg::CORDIC_STEPS_MAX : STEPS;
	localparam int IW = $clog2(NSTEP);

	logic signed [51:0] x_q;
	logic signed [51:0] y_q;
	logic signed [20:0] z_q;
	logic [IW-1:0]      i_q;
	logic               busy_q;
	logic               done_q;
	logic               zero_q;
	logic signed [51:0] dx;
	logic signed [51:0] dy;
	logic signed [51:0] sx;
	logic signed [51:0] sy;
	logic signed [20:0] at;

	assign sx = {{3{ex[32]}}, ex, 16'd0};
	assign sy = {{3{ey[32]}}, ey, 16'd0};
	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;
	assign at = wpdc_pkg::atan_q(5'(i_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == IW'(NSTEP - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (ex == '0) && (ey == '0);
			if (ex[32]) begin
				x_q <= -sx;
				y_q <= -sy;
				z_q <= ey[32] ? -wpdc_pkg::PI_Q : wpdc_pkg::PI_Q;
			end else begin
				x_q <= sx;
				y_q <= sy;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (!y_q[51]) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end
		end
	end

	assign done = done_q;
	assign mag  = zero_q ? '0 : x_q[51:8];
	assign ang  = zero_q ? '0 : z_q;
endmodule
`default_nettype wire

@@ rtl/waypoint_pid_drive_controller_unit.sv @@
// Top level: go-to-goal PID drive controller with shared CORDIC and multiplier.
// Sequence: after the input word is taken, out_valid rises once CORDIC vectoring and then
// 11 multiplies are through; with goal_done it is answered with zero velocities at once.
// A new word is taken only after the last result is loaded into the output register
// (in_stall is high outside idle), so an output stall holds off the next word too.
// Reset: gains clear, tick_period 6554, tick_rate 655360, PID state zero.
`default_nettype none
module waypoint_pid_drive_controller_unit #(
	parameter int CORDIC_STEPS = wpdc_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [31:0] goal_x,
	input  wire logic signed [31:0] goal_y,
	input  wire logic signed [31:0] robot_x,
	input  wire logic signed [31:0] robot_y,
	input  wire logic signed [18:0] robot_heading,
	input  wire logic               goal_done,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [16:0]      linear_velocity,
	output logic signed [18:0]      angular_velocity
);
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CORD   = 3'd1;
	localparam logic [2:0] ST_MSTART = 3'd2;
	localparam logic [2:0] ST_MWAIT  = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	localparam logic [3:0] OP_DIST  = 4'd0;
	localparam logic [3:0] OP_DI    = 4'd1;
	localparam logic [3:0] OP_HI    = 4'd2;
	localparam logic [3:0] OP_DD    = 4'd3;
	localparam logic [3:0] OP_DH    = 4'd4;
	localparam logic [3:0] OP_ANG_P = 4'd5;
	localparam logic [3:0] OP_ANG_I = 4'd6;
	localparam logic [3:0] OP_ANG_D = 4'd7;
	localparam logic [3:0] OP_LIN_P = 4'd8;
	localparam logic [3:0] OP_LIN_I = 4'd9;
	localparam logic [3:0] OP_LIN_D = 4'd10;

	logic signed [31:0] gpa_q, gia_q, gda_q, gpl_q, gil_q, gdl_q;
	logic [16:0]        tp_q;
	logic [31:0]        tr_q;

	logic signed [33:0] ld_q;
	logic signed [18:0] lh_q;
	wpdc_pkg::q48_t     di_q;
	wpdc_pkg::q48_t     hi_q;

	logic [2:0]         state_q;
	logic [3:0]         op_q;
	logic signed [18:0] head_q;
	logic signed [33:0] dist_q;
	logic signed [18:0] herr_q;
	wpdc_pkg::q48_t     dd_q;
	wpdc_pkg::q48_t     dh_q;
	logic signed [49:0] acc_q;
	logic signed [16:0] lin_res_q;
	logic signed [18:0] ang_res_q;
	logic               out_valid_q;
	logic signed [16:0] lin_out_q;
	logic signed [18:0] ang_out_q;

	logic               accept;
	logic               out_load;
	logic               cord_done;
	logic [43:0]        cord_mag;
	logic signed [20:0] cord_ang;
	logic signed [32:0] ex;
	logic signed [32:0] ey;
	logic               mul_start;
	logic signed [32:0] mul_a;
	logic signed [49:0] mul_b;
	logic               mul_done;
	logic               mul_neg;
	logic [81:0]        mul_p;
	wpdc_pkg::q48_t     mq;
	logic [81:0]        dist_sum;
	logic signed [21:0] herr_raw;
	logic signed [21:0] herr_w;
	logic signed [49:0] acc_next;
	logic signed [34:0] ddiff;
	logic signed [19:0] hdiff;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign ex        = 33'(goal_x) - 33'(robot_x);
	assign ey        = 33'(goal_y) - 33'(robot_y);
	assign mul_start = (state_q == ST_MSTART);
	assign mq        = wpdc_pkg::mulq_fix(mul_p, mul_neg);
	assign dist_sum  = mul_p + 82'd134217728;
	assign herr_raw  = 22'(cord_ang) - 22'(head_q);
	assign ddiff     = 35'(ld_q) - 35'(dist_q);
	assign hdiff     = 20'(lh_q) - 20'(herr_q);
	assign acc_next  = acc_q + 50'(mq);

	always_comb begin
		herr_w = herr_raw;
		if (herr_raw < -22'(wpdc_pkg::PI_Q)) begin
			herr_w = herr_raw + wpdc_pkg::TWO_PI_Q;
		end
		if (herr_w > 22'(wpdc_pkg::PI_Q)) begin
			herr_w = herr_w - wpdc_pkg::TWO_PI_Q;
		end
	end

	always_comb begin
		unique case (op_q)
			OP_DIST:  begin mul_a = wpdc_pkg::KINV_Q20; mul_b = 50'(cord_mag); end
			OP_DI:    begin mul_a = 33'(tp_q); mul_b = 50'(dist_q); end
			OP_HI:    begin mul_a = 33'(tp_q); mul_b = 50'(herr_q); end
			OP_DD:    begin mul_a = 33'(tr_q); mul_b = 50'(ddiff); end
			OP_DH:    begin mul_a = 33'(tr_q); mul_b = 50'(hdiff); end
			OP_ANG_P: begin mul_a = 33'(gpa_q); mul_b = 50'(herr_q); end
			OP_ANG_I: begin mul_a = 33'(gia_q); mul_b = 50'(hi_q); end
			OP_ANG_D: begin mul_a = 33'(gda_q); mul_b = 50'(dh_q); end
			OP_LIN_P: begin mul_a = 33'(gpl_q); mul_b = 50'(dist_q); end
			OP_LIN_I: begin mul_a = 33'(gil_q); mul_b = 50'(di_q); end
			OP_LIN_D: begin mul_a = 33'(gdl_q); mul_b = 50'(dd_q); end
			default:  begin mul_a = '0; mul_b = '0; end
		endcase
	end

	function automatic logic signed [16:0] clamp_lin(input logic signed [49:0] v);
		logic signed [16:0] r;
		if (v > 50'(wpdc_pkg::LIN_MAX)) begin
			r = 17'(wpdc_pkg::LIN_MAX);
		end else if (v < -50'(wpdc_pkg::LIN_MAX)) begin
			r = 17'(-wpdc_pkg::LIN_MAX);
		end else begin
			r = v[16:0];
		end
		return r;
	endfunction

	function automatic logic signed [18:0] clamp_ang(input logic signed [49:0] v);
		logic signed [18:0] r;
		if (v > 50'(wpdc_pkg::PI_Q)) begin
			r = 19'(wpdc_pkg::PI_Q);
		end else if (v < -50'(wpdc_pkg::PI_Q)) begin
			r = 19'(-wpdc_pkg::PI_Q);
		end else begin
			r = v[18:0];
		end
		return r;
	endfunction

	wpdc_cordic #(
		.STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && !goal_done),
		.ex     (ex),
		.ey     (ey),
		.done   (cord_done),
		.mag    (cord_mag),
		.ang    (cord_ang)
	);

	wpdc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.neg    (mul_neg),
		.prod   (mul_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gpa_q <= '0;
			gia_q <= '0;
			gda_q <= '0;
			gpl_q <= '0;
			gil_q <= '0;
			gdl_q <= '0;
			tp_q  <= 17'd6554;
			tr_q  <= 32'd655360;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wpdc_pkg::REG_GPA: gpa_q <= cfg_data;
				wpdc_pkg::REG_GIA: gia_q <= cfg_data;
				wpdc_pkg::REG_GDA: gda_q <= cfg_data;
				wpdc_pkg::REG_GPL: gpl_q <= cfg_data;
				wpdc_pkg::REG_GIL: gil_q <= cfg_data;
				wpdc_pkg::REG_GDL: gdl_q <= cfg_data;
				wpdc_pkg::REG_TP:  tp_q  <= cfg_data[16:0];
				wpdc_pkg::REG_TR:  tr_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_DIST;
			out_valid_q <= 1'b0;
			ld_q        <= '0;
			lh_q        <= '0;
			di_q        <= '0;
			hi_q        <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= goal_done ? ST_DONE : ST_CORD;
					end
				end
				ST_CORD: begin
					if (cord_done) begin
						op_q    <= OP_DIST;
						state_q <= ST_MSTART;
					end
				end
				ST_MSTART: begin
					state_q <= ST_MWAIT;
				end
				ST_MWAIT: begin
					if (mul_done) begin
						if (op_q == OP_DI) begin
							di_q <= wpdc_pkg::sat48(49'(di_q) + 49'(mq));
						end
						if (op_q == OP_HI) begin
							hi_q <= wpdc_pkg::sat48(49'(hi_q) + 49'(mq));
						end
						if (op_q == OP_LIN_D) begin
							ld_q    <= dist_q;
							lh_q    <= herr_q;
							state_q <= ST_DONE;
						end else begin
							op_q    <= op_q + 4'd1;
							state_q <= ST_MSTART;
						end
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			head_q    <= robot_heading;
			lin_res_q <= '0;
			ang_res_q <= '0;
		end
		if (state_q == ST_CORD && cord_done) begin
			herr_q <= herr_w[18:0];
		end
		if (state_q == ST_MWAIT && mul_done) begin
			unique case (op_q)
				OP_DIST:  dist_q <= dist_sum[61:28];
				OP_DD:    dd_q <= mq;
				OP_DH:    dh_q <= mq;
				OP_ANG_P: acc_q <= 50'(mq);
				OP_ANG_I: acc_q <= acc_next;
				OP_ANG_D: ang_res_q <= clamp_ang(acc_next);
				OP_LIN_P: acc_q <= 50'(mq);
				OP_LIN_I: acc_q <= acc_next;
				OP_LIN_D: lin_res_q <= clamp_lin(acc_next);
				default: ;
			endcase
		end
		if (out_load) begin
			lin_out_q <= lin_res_q;
			ang_out_q <= ang_res_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign linear_velocity  = lin_out_q;
	assign angular_velocity = ang_out_q;
endmodule
`default_nettype wire
